// ===== src/lhcb_pkg.sv =====
// Shared types and constants for the letter Huffman code builder.
// No dependencies; imported by lhcb_ram users and the top level.
package lhcb_pkg;

  // Default configuration
  localparam int NUM_SYMBOLS_DEF = 26;
  localparam int COUNT_WIDTH_DEF = 24;

  // Fixed field widths
  localparam int CHAR_W    = 8;
  localparam int SYM_IDX_W = 5;
  localparam int CODE_W    = 25;
  localparam int LEN_W     = 5;
  localparam int WEIGHT_W  = 32;

  // Character codes used for case folding
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_SCAN,
    ST_SCAN_END,
    ST_MERGE,
    ST_MERGE_HI,
    ST_EMIT_START,
    ST_EMIT_STEP
  } state_t;

endpackage

// ===== src/lhcb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lhcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a same-edge write is not seen by the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/letter_huffman_code_builder.sv =====
// Letter histogram and Huffman code builder, top level.
// Depends on lhcb_pkg and lhcb_ram.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  input     | start high, busy low   | char_byte, end_of_text
//  result    | code_valid, one cycle  | symbol_index, code_bits, code_length,
//            |                        | last_symbol
//
// Bytes are taken one per cycle while busy is low; the count RAM update is a
// two-stage read-modify-write with forwarding between back-to-back bytes.
// After the final byte: a flush state, then each merge k = N..2N-2 scans
// nodes 0..k-1 through the weight RAMs.
// Emission walks from each symbol's leaf up to the root; results cannot be held off.
// busy is high from the final byte until the last result; rst clears the histogram.
module letter_huffman_code_builder #(
  parameter int NUM_SYMBOLS = lhcb_pkg::NUM_SYMBOLS_DEF,
  parameter int COUNT_WIDTH = lhcb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [lhcb_pkg::CHAR_W-1:0]    char_byte,
  input  logic                           end_of_text,
  output logic                           code_valid,
  output logic [lhcb_pkg::SYM_IDX_W-1:0] symbol_index,
  output logic [lhcb_pkg::CODE_W-1:0]    code_bits,
  output logic [lhcb_pkg::LEN_W-1:0]     code_length,
  output logic                           last_symbol
);

  import lhcb_pkg::*;

  localparam int NODE_TOTAL = 2 * NUM_SYMBOLS - 1;
  localparam int NODE_W     = $clog2(NODE_TOTAL);
  localparam int SYM_W      = $clog2(NUM_SYMBOLS);
  localparam int INT_DEPTH  = NUM_SYMBOLS - 1;
  localparam int INT_W      = (INT_DEPTH > 1) ? $clog2(INT_DEPTH) : 1;
  localparam logic [NODE_W-1:0] ROOT      = NODE_W'(NODE_TOTAL - 1);
  localparam logic [NODE_W-1:0] NODE_NSYM = NODE_W'(NUM_SYMBOLS);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  state_t state, state_next;

  // ---------------------------------------------------------------
  // Input decode: case fold and range check
  logic             accept;
  logic [CHAR_W-1:0] letter_idx;
  logic             is_letter;
  logic             in_range;
  logic [SYM_W-1:0] in_sym;

  always_comb begin
    is_letter  = 1'b0;
    letter_idx = '0;
    if (char_byte >= CHAR_LOWER_A && char_byte <= CHAR_LOWER_Z) begin
      is_letter  = 1'b1;
      letter_idx = char_byte - CASE_OFFSET - CHAR_UPPER_A;
    end else if (char_byte >= CHAR_UPPER_A && char_byte <= CHAR_UPPER_Z) begin
      is_letter  = 1'b1;
      letter_idx = char_byte - CHAR_UPPER_A;
    end
    in_range = is_letter && (letter_idx < CHAR_W'(NUM_SYMBOLS));
    in_sym   = letter_idx[SYM_W-1:0];
  end

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // ---------------------------------------------------------------
  // Histogram RAM with per-entry valid bits
  logic [NUM_SYMBOLS-1:0] cnt_valid;
  logic                   cnt_we;
  logic [SYM_W-1:0]       cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_rd;

  // Counting stage and write-back record for forwarding
  logic                   s1_valid;
  logic [SYM_W-1:0]       s1_sym;
  logic                   s1_vbit;
  logic                   wb_valid;
  logic [SYM_W-1:0]       wb_sym;
  logic [COUNT_WIDTH-1:0] wb_data;
  logic [COUNT_WIDTH-1:0] cnt_old;
  logic [COUNT_WIDTH-1:0] cnt_new;

  always_comb begin
    if (wb_valid && wb_sym == s1_sym) begin
      cnt_old = wb_data;
    end else if (s1_vbit) begin
      cnt_old = cnt_rd;
    end else begin
      cnt_old = '0;
    end
    cnt_new = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + COUNT_WIDTH'(1);
  end

  assign cnt_we = s1_valid;

  lhcb_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_SYMBOLS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (s1_sym),
    .wdata (cnt_new),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  // ---------------------------------------------------------------
  // Internal node weights and node parent/side store
  logic                       wt_we;
  logic [INT_W-1:0]           wt_waddr;
  logic [INT_W-1:0]           wt_raddr;
  logic [WEIGHT_W-1:0]        wt_wdata;
  logic [WEIGHT_W-1:0]        wt_rd;
  logic                       par_we;
  logic [NODE_W-1:0]          par_waddr;
  logic [NODE_W:0]            par_wdata;
  logic [NODE_W-1:0]          par_raddr;
  logic [NODE_W:0]            par_rd;
  logic [NODE_W-1:0]          par_parent;
  logic                       par_right;

  assign par_parent = par_rd[NODE_W:1];
  assign par_right  = par_rd[0];

  lhcb_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (INT_DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .raddr (wt_raddr),
    .rdata (wt_rd)
  );

  lhcb_ram #(
    .WIDTH (NODE_W + 1),
    .DEPTH (NODE_TOTAL)
  ) u_parent_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rd)
  );

  // ---------------------------------------------------------------
  // Build and emission registers
  logic [NODE_W-1:0]     k_node;
  logic [NODE_W-1:0]     scan_x;
  logic                  d_valid;
  logic [NODE_W-1:0]     d_x;
  logic [NODE_TOTAL-1:0] merged;
  logic                  lo_ok, hi_ok;
  logic [NODE_W-1:0]     lo_idx, hi_idx;
  logic [WEIGHT_W-1:0]   lo_w, hi_w;
  logic [WEIGHT_W-1:0]   d_w;
  logic [WEIGHT_W:0]     pair_sum;
  logic [SYM_W-1:0]      emit_sym;
  logic [CODE_W-1:0]     walk_code;
  logic [LEN_W-1:0]      walk_len;
  logic [CODE_W-1:0]     step_code;
  logic [LEN_W-1:0]      step_len;
  logic                  emit_last;
  logic [NODE_W-1:0]     k_off;
  logic [NODE_W-1:0]     x_off;

  // Weight of the node whose data just came back
  always_comb begin
    if (d_x < NODE_NSYM) begin
      d_w = cnt_valid[d_x[SYM_W-1:0]] ? WEIGHT_W'(cnt_rd) : '0;
    end else begin
      d_w = wt_rd;
    end
  end

  assign pair_sum  = {1'b0, lo_w} + {1'b0, hi_w};
  assign step_code = walk_code | (CODE_W'(par_right) << walk_len);
  assign step_len  = walk_len + LEN_W'(1);
  assign emit_last = (emit_sym == SYM_W'(NUM_SYMBOLS - 1));
  assign k_off     = k_node - NODE_NSYM;
  assign x_off     = scan_x - NODE_NSYM;

  // ---------------------------------------------------------------
  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && end_of_text) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH:    state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_x == k_node - NODE_W'(1)) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_next = ST_MERGE;
      ST_MERGE:    state_next = ST_MERGE_HI;
      ST_MERGE_HI: begin
        state_next = (k_node == ROOT) ? ST_EMIT_START : ST_SCAN;
      end
      ST_EMIT_START: state_next = ST_EMIT_STEP;
      ST_EMIT_STEP: begin
        if (par_parent == ROOT) begin
          state_next = emit_last ? ST_IDLE : ST_EMIT_START;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    cnt_raddr = in_sym;
    wt_we     = 1'b0;
    wt_waddr  = k_off[INT_W-1:0];
    wt_wdata  = pair_sum[WEIGHT_W] ? {WEIGHT_W{1'b1}} : pair_sum[WEIGHT_W-1:0];
    wt_raddr  = x_off[INT_W-1:0];
    par_we    = 1'b0;
    par_waddr = lo_idx;
    par_wdata = {k_node, 1'b0};
    par_raddr = NODE_W'(emit_sym);
    unique case (state)
      ST_IDLE:       cnt_raddr = in_sym;
      ST_FLUSH:      cnt_raddr = in_sym;
      ST_SCAN:       cnt_raddr = scan_x[SYM_W-1:0];
      ST_SCAN_END:   cnt_raddr = scan_x[SYM_W-1:0];
      ST_MERGE: begin
        wt_we  = 1'b1;
        par_we = 1'b1;
      end
      ST_MERGE_HI: begin
        par_we    = 1'b1;
        par_waddr = hi_idx;
        par_wdata = {k_node, 1'b1};
      end
      ST_EMIT_START: par_raddr = NODE_W'(emit_sym);
      ST_EMIT_STEP:  par_raddr = par_parent;
      default:       cnt_raddr = in_sym;
    endcase
  end

  // ---------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      s1_valid   <= 1'b0;
      wb_valid   <= 1'b0;
      cnt_valid  <= '0;
      d_valid    <= 1'b0;
      code_valid <= 1'b0;
    end else begin
      state      <= state_next;
      s1_valid   <= accept && in_range;
      wb_valid   <= s1_valid;
      d_valid    <= (state == ST_SCAN);
      code_valid <= (state == ST_EMIT_STEP) && (par_parent == ROOT);
      if (s1_valid) begin
        cnt_valid[s1_sym] <= 1'b1;
      end
      // Histogram restarts after the final result
      if (state == ST_EMIT_STEP && par_parent == ROOT && emit_last) begin
        cnt_valid <= '0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Datapath registers
  always_ff @(posedge clk) begin
    s1_sym  <= in_sym;
    s1_vbit <= cnt_valid[in_sym];
    wb_sym  <= s1_sym;
    wb_data <= cnt_new;
    d_x     <= scan_x;

    // Two smallest unmerged nodes, lower index wins ties
    if (d_valid && !merged[d_x]) begin
      if (!lo_ok || d_w < lo_w) begin
        hi_ok  <= lo_ok;
        hi_idx <= lo_idx;
        hi_w   <= lo_w;
        lo_ok  <= 1'b1;
        lo_idx <= d_x;
        lo_w   <= d_w;
      end else if (!hi_ok || d_w < hi_w) begin
        hi_ok  <= 1'b1;
        hi_idx <= d_x;
        hi_w   <= d_w;
      end
    end

    case (state)
      ST_FLUSH: begin
        k_node <= NODE_NSYM;
        scan_x <= '0;
        lo_ok  <= 1'b0;
        hi_ok  <= 1'b0;
        merged <= '0;
      end
      ST_SCAN: begin
        scan_x <= scan_x + NODE_W'(1);
      end
      ST_MERGE: begin
        merged[lo_idx] <= 1'b1;
        merged[hi_idx] <= 1'b1;
      end
      ST_MERGE_HI: begin
        k_node    <= k_node + NODE_W'(1);
        scan_x    <= '0;
        lo_ok     <= 1'b0;
        hi_ok     <= 1'b0;
        emit_sym  <= '0;
        walk_code <= '0;
        walk_len  <= '0;
      end
      ST_EMIT_STEP: begin
        if (par_parent == ROOT) begin
          symbol_index <= SYM_IDX_W'(emit_sym);
          code_bits    <= step_code;
          code_length  <= step_len;
          last_symbol  <= emit_last;
          emit_sym     <= emit_sym + SYM_W'(1);
          walk_code    <= '0;
          walk_len     <= '0;
        end else begin
          walk_code <= step_code;
          walk_len  <= step_len;
        end
      end
      default: begin
        walk_len <= walk_len;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Results only come out of a build
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> $past(busy))
    else $error("result strobe without a build in progress");

  // The final result releases the block
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (code_valid && last_symbol) |-> !busy)
    else $error("block still busy after final result");

  // Every merge has two distinct children
  a_merge_pair: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |-> (lo_ok && hi_ok && lo_idx != hi_idx))
    else $error("merge without two distinct nodes");

  // Every code word has at least one bit
  a_code_len: assert property (@(posedge clk) disable iff (rst)
    code_valid |-> (code_length != '0))
    else $error("empty code word");
`endif

endmodule
